>>> rtl/core/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg: shared constants and the arctangent table for the clifford attractor stepper
// field widths, register indexes, reset values and q30 angle constants
// ----------------------------------------------------------------------------
package cas_pkg;

    localparam int COEF_W     = 20;
    localparam int SCALE_W    = 10;
    localparam int FLEN_W     = 17;
    localparam int XY_W       = 30;
    localparam int Z_W        = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CORDIC_W   = 36;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 3'd5;

    localparam logic signed [COEF_W-1:0] RST_COEF_A = 20'sd91750;
    localparam logic signed [COEF_W-1:0] RST_COEF_B = 20'sd104858;
    localparam logic signed [COEF_W-1:0] RST_COEF_C = 20'sd65536;
    localparam logic signed [COEF_W-1:0] RST_COEF_D = 20'sd111411;
    localparam logic [SCALE_W-1:0]       RST_SCALE  = 10'd100;
    localparam logic [FLEN_W-1:0]        RST_FLEN   = 17'd30000;

    localparam logic signed [CORDIC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CORDIC_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 36'sd652032874;

    // arctan(2^-i) in q30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/cas_if.sv
// ----------------------------------------------------------------------------
// cas_if: stream and configuration channels
// valid/ready channels for input beats, result beats and register writes
// ----------------------------------------------------------------------------
interface cas_in_if;
    import cas_pkg::*;
    logic valid;
    logic ready;
    logic restart;
    modport source(output valid, output restart, input ready);
    modport sink(input valid, input restart, output ready);
endinterface

interface cas_out_if;
    import cas_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [XY_W-1:0]  x_scaled;
    logic signed [XY_W-1:0]  y_scaled;
    logic signed [Z_W-1:0]   z_scaled;
    logic [FLEN_W-1:0]       point_index;
    logic                    last_in_frame;
    modport source(output valid, output x_scaled, output y_scaled, output z_scaled,
                   output point_index, output last_in_frame, input ready);
    modport sink(input valid, input x_scaled, input y_scaled, input z_scaled,
                 input point_index, input last_in_frame, output ready);
endinterface

interface cas_cfg_if;
    import cas_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/core/cas_sincos.sv
// ----------------------------------------------------------------------------
// cas_sincos: iterative sine and cosine
// restoring range reduction mod 2pi, quadrant fold, then one cordic rotation
// per cycle through a single shift/add datapath
// ----------------------------------------------------------------------------
module cas_sincos #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 18,
    parameter int ANG_W        = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic                     o_done,
    output logic signed [FRAC_BITS+1:0] o_sin,
    output logic signed [FRAC_BITS+1:0] o_cos
);
    import cas_pkg::*;

    localparam int RW      = ANG_W + 30 - FRAC_BITS;
    localparam int RED_N   = (RW > 32) ? RW - 32 : 1;
    localparam int MW      = 33 + RED_N;
    localparam int OW      = FRAC_BITS + 2;
    localparam int RSH     = 30 - FRAC_BITS;
    localparam int CNT_MAX = (RED_N > CORDIC_ITERS) ? RED_N : CORDIC_ITERS;
    localparam int CNTW    = $clog2(CNT_MAX + 1);
    localparam logic signed [CORDIC_W-1:0] RND_BIAS = CORDIC_W'(64'sd1 <<< (RSH - 1));

    typedef enum logic [2:0] {S_IDLE, S_RED, S_FOLD, S_ROT, S_RND} t_state;

    t_state                       r_state;
    logic [CNTW-1:0]              r_cnt;
    logic                         r_neg;
    logic [MW-1:0]                r_rem;
    logic signed [CORDIC_W-1:0]   r_x;
    logic signed [CORDIC_W-1:0]   r_y;
    logic signed [CORDIC_W-1:0]   r_z;
    logic                         r_negc;
    logic                         r_done;
    logic signed [OW-1:0]         r_sin;
    logic signed [OW-1:0]         r_cos;

    logic signed [RW-1:0]         w_r;
    logic signed [MW:0]           w_rx;
    logic [MW-1:0]                w_mag;
    logic [MW-1:0]                w_sub;
    logic [MW-1:0]                w_wrap;
    logic signed [CORDIC_W-1:0]   w_t;
    logic signed [CORDIC_W-1:0]   w_t2;
    logic signed [CORDIC_W-1:0]   w_zf;
    logic                         w_nc;
    logic signed [CORDIC_W-1:0]   w_dx;
    logic signed [CORDIC_W-1:0]   w_dy;
    logic signed [CORDIC_W-1:0]   w_at;
    logic signed [CORDIC_W-1:0]   w_xo;
    logic signed [CORDIC_W-1:0]   w_sr;
    logic signed [CORDIC_W-1:0]   w_cr;

    assign w_r   = RW'(i_angle) <<< RSH;
    assign w_rx  = (MW + 1)'(w_r);
    assign w_mag = MW'(w_rx[MW] ? -w_rx : w_rx);
    assign w_sub = MW'(TWO_PI_Q30) << r_cnt;

    // truncating remainder turned into floor remainder, then folded into +-pi/2
    always_comb begin
        w_wrap = (r_neg && r_rem != '0) ? MW'(TWO_PI_Q30) - r_rem : r_rem;
        w_t    = CORDIC_W'(w_wrap);
        w_t2   = (w_t > PI_Q30) ? w_t - TWO_PI_Q30 : w_t;
        if (w_t2 > HALF_PI_Q30) begin
            w_zf = PI_Q30 - w_t2;
            w_nc = 1'b1;
        end else if (w_t2 < -HALF_PI_Q30) begin
            w_zf = -PI_Q30 - w_t2;
            w_nc = 1'b1;
        end else begin
            w_zf = w_t2;
            w_nc = 1'b0;
        end
    end

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;
    assign w_at = CORDIC_W'(atan_q30(5'(r_cnt)));
    assign w_xo = r_negc ? -r_x : r_x;
    assign w_sr = (r_y + RND_BIAS) >>> RSH;
    assign w_cr = (w_xo + RND_BIAS) >>> RSH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem   <= w_mag;
                        r_neg   <= w_r[RW-1];
                        r_cnt   <= CNTW'(RED_N - 1);
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_rem >= w_sub) begin
                        r_rem <= r_rem - w_sub;
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_cnt <= r_cnt - CNTW'(1);
                    end
                end
                S_FOLD: begin
                    r_x     <= GAIN_Q30;
                    r_y     <= '0;
                    r_z     <= w_zf;
                    r_negc  <= w_nc;
                    r_cnt   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end
                    if (r_cnt == CNTW'(CORDIC_ITERS - 1)) begin
                        r_state <= S_RND;
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                S_RND: begin
                    r_sin   <= OW'(w_sr);
                    r_cos   <= OW'(w_cr);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

>>> rtl/core/clifford_attractor_step_top.sv
// flow: a new input beat is taken only in the idle state, after the previous
//   result is in the output register; one sine/cosine unit runs five angles in
//   turn, each with R = max(22 - FRAC_BITS, 1) range reduction steps, and one
//   multiplier is shared by all products
// reset: synchronous active low; coefficients to defaults, position 1.0, index 0
// ----------------------------------------------------------------------------
// clifford_attractor_step_top: clifford map stepper
// advances x,y one step per input beat and emits scaled point, z and index
// ----------------------------------------------------------------------------
module clifford_attractor_step_top #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 18
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cas_in_if.sink    i_in,
    cas_out_if.source o_out,
    cas_cfg_if.sink   i_cfg
);
    import cas_pkg::*;

    localparam int POS_BITS = FRAC_BITS + 4;
    localparam int PW       = COEF_W + POS_BITS;
    localparam int ANG_W    = PW - FRAC_BITS;
    localparam int OW       = FRAC_BITS + 2;
    localparam logic signed [POS_BITS-1:0] POS_ONE = POS_BITS'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PW:0] SAT_HI = (PW + 1)'((64'sd1 <<< (POS_BITS - 1)) - 1);
    localparam logic signed [PW:0] SAT_LO = (PW + 1)'(-(64'sd1 <<< (POS_BITS - 1)));

    localparam logic [2:0] ANG_AY = 3'd0;
    localparam logic [2:0] ANG_AX = 3'd1;
    localparam logic [2:0] ANG_BX = 3'd2;
    localparam logic [2:0] ANG_BY = 3'd3;
    localparam logic [2:0] ANG_X  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ANG, S_WAIT, S_MC, S_MD, S_SX, S_SY, S_SZ, S_OUT
    } t_state;

    t_state                      r_state;
    logic [2:0]                  r_ang;
    logic signed [COEF_W-1:0]    r_coef_a;
    logic signed [COEF_W-1:0]    r_coef_b;
    logic signed [COEF_W-1:0]    r_coef_c;
    logic signed [COEF_W-1:0]    r_coef_d;
    logic [SCALE_W-1:0]          r_scale;
    logic [FLEN_W-1:0]           r_flen;
    logic signed [POS_BITS-1:0]  r_pos_x;
    logic signed [POS_BITS-1:0]  r_pos_y;
    logic [FLEN_W-1:0]           r_frame_cnt;
    logic signed [PW-1:0]        r_prod;
    logic signed [OW-1:0]        r_s1;
    logic signed [OW-1:0]        r_c2;
    logic signed [OW-1:0]        r_s3;
    logic signed [OW-1:0]        r_c4;
    logic signed [OW-1:0]        r_cz;
    logic signed [POS_BITS-1:0]  r_nx;
    logic signed [POS_BITS-1:0]  r_ny;
    logic signed [XY_W-1:0]      r_tx;
    logic signed [XY_W-1:0]      r_ty;
    logic [FLEN_W-1:0]           r_idx;
    logic                        r_last;
    logic                        r_oval;
    logic signed [XY_W-1:0]      r_ox;
    logic signed [XY_W-1:0]      r_oy;
    logic signed [Z_W-1:0]       r_oz;
    logic [FLEN_W-1:0]           r_oidx;
    logic                        r_olast;

    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_load;
    logic signed [COEF_W-1:0]    w_ma;
    logic signed [POS_BITS-1:0]  w_mb;
    logic signed [PW-1:0]        w_prod;
    logic signed [ANG_W-1:0]     w_angle;
    logic                        w_done;
    logic signed [OW-1:0]        w_sin;
    logic signed [OW-1:0]        w_cos;
    logic signed [OW-1:0]        w_sadd;
    logic signed [PW:0]          w_sum;
    logic signed [POS_BITS-1:0]  w_sat;
    logic [FLEN_W-1:0]           w_fl;
    logic [FLEN_W-1:0]           w_cur;
    logic [FLEN_W-1:0]           w_idx;
    logic [FLEN_W:0]             w_inc;
    logic [FLEN_W-1:0]           w_next;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = r_oval && o_out.ready;
    assign w_load      = (r_state == S_OUT) && (!r_oval || o_out.ready);

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_MUL: begin
                w_ma = (r_ang == ANG_AY || r_ang == ANG_AX) ? r_coef_a : r_coef_b;
                w_mb = (r_ang == ANG_AY || r_ang == ANG_BY) ? r_pos_y : r_pos_x;
            end
            S_MC: begin
                w_ma = r_coef_c;
                w_mb = POS_BITS'(r_c2);
            end
            S_MD: begin
                w_ma = r_coef_d;
                w_mb = POS_BITS'(r_c4);
            end
            S_SX: begin
                w_ma = COEF_W'(r_scale);
                w_mb = r_nx;
            end
            S_SY: begin
                w_ma = COEF_W'(r_scale);
                w_mb = r_ny;
            end
            S_SZ: begin
                w_ma = COEF_W'(r_scale);
                w_mb = POS_BITS'(r_cz);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod  = w_ma * w_mb;
    assign w_angle = (r_ang == ANG_X) ? ANG_W'(r_pos_x) : ANG_W'(r_prod >>> FRAC_BITS);

    assign w_sadd = (r_state == S_MD) ? r_s1 : r_s3;
    assign w_sum  = (PW + 1)'(w_sadd) + (PW + 1)'(r_prod >>> FRAC_BITS);
    assign w_sat  = (w_sum > SAT_HI) ? POS_BITS'(SAT_HI) :
                    (w_sum < SAT_LO) ? POS_BITS'(SAT_LO) : POS_BITS'(w_sum);

    // frame index, a zero length acts as one
    always_comb begin
        w_fl   = (r_flen == '0) ? FLEN_W'(1) : r_flen;
        w_cur  = i_in.restart ? '0 : r_frame_cnt;
        w_idx  = (w_cur >= w_fl) ? '0 : w_cur;
        w_inc  = (FLEN_W + 1)'(w_idx) + (FLEN_W + 1)'(1);
        w_next = (w_inc >= (FLEN_W + 1)'(w_fl)) ? '0 : FLEN_W'(w_inc);
    end

    cas_sincos #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_ITERS (CORDIC_ITERS),
        .ANG_W        (ANG_W)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ANG),
        .i_angle (w_angle),
        .o_done  (w_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ang       <= ANG_AY;
            r_coef_a    <= RST_COEF_A;
            r_coef_b    <= RST_COEF_B;
            r_coef_c    <= RST_COEF_C;
            r_coef_d    <= RST_COEF_D;
            r_scale     <= RST_SCALE;
            r_flen      <= RST_FLEN;
            r_pos_x     <= POS_ONE;
            r_pos_y     <= POS_ONE;
            r_frame_cnt <= '0;
            r_oval      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_COEF_A:    r_coef_a <= i_cfg.data;
                    REG_COEF_B:    r_coef_b <= i_cfg.data;
                    REG_COEF_C:    r_coef_c <= i_cfg.data;
                    REG_COEF_D:    r_coef_d <= i_cfg.data;
                    REG_SCALE:     r_scale  <= SCALE_W'(i_cfg.data);
                    REG_FRAME_LEN: r_flen   <= FLEN_W'(i_cfg.data);
                    default: ;
                endcase
            end
            if (w_load) begin
                r_oval <= 1'b1;
            end else if (w_out_acc) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.restart) begin
                            r_pos_x <= POS_ONE;
                            r_pos_y <= POS_ONE;
                        end
                        r_idx       <= w_idx;
                        r_last      <= (w_idx == w_fl - FLEN_W'(1));
                        r_frame_cnt <= w_next;
                        r_ang       <= ANG_AY;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_ANG;
                end
                S_ANG: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_done) begin
                        unique case (r_ang)
                            ANG_AY: r_s1 <= w_sin;
                            ANG_AX: r_c2 <= w_cos;
                            ANG_BX: r_s3 <= w_sin;
                            ANG_BY: r_c4 <= w_cos;
                            default: r_cz <= w_cos;
                        endcase
                        if (r_ang == ANG_X) begin
                            r_state <= S_MC;
                        end else begin
                            r_ang   <= r_ang + 3'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MC: begin
                    r_prod  <= w_prod;
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_nx    <= w_sat;
                    r_prod  <= w_prod;
                    r_state <= S_SX;
                end
                S_SX: begin
                    r_ny    <= w_sat;
                    r_prod  <= w_prod;
                    r_state <= S_SY;
                end
                S_SY: begin
                    r_tx    <= XY_W'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_SZ;
                end
                S_SZ: begin
                    r_ty    <= XY_W'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold here until the output register is free
                    if (w_load) begin
                        r_ox    <= r_tx;
                        r_oy    <= r_ty;
                        r_oz    <= Z_W'(r_prod);
                        r_oidx  <= r_idx;
                        r_olast <= r_last;
                        r_pos_x <= r_nx;
                        r_pos_y <= r_ny;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_oval;
    assign o_out.x_scaled      = r_ox;
    assign o_out.y_scaled      = r_oy;
    assign o_out.z_scaled      = r_oz;
    assign o_out.point_index   = r_oidx;
    assign o_out.last_in_frame = r_olast;

`ifndef NO_ASSERTIONS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_WAIT)
        else $error("sine/cosine result arrived outside the wait state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_MUL && r_ang == ANG_AY)
        else $error("accepted beat did not start the first angle");

    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_oval || o_out.ready)) |=> r_oval && r_state == S_IDLE)
        else $error("finished step did not reach the output register");
`endif

endmodule

>>> tb/clifford_attractor_step_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clifford_attractor_step_top_test: self-checking bench for the map stepper
// drives restart beats and register writes, predicts every point with a
// bit-accurate cordic model and checks each result beat field by field
// ----------------------------------------------------------------------------
module clifford_attractor_step_top_test;
    import cas_pkg::*;

    localparam int FRAC     = 16;
    localparam int ITERS    = 18;
    localparam int POS_W    = FRAC + 4;
    localparam int LATENCY  = 200;
    localparam longint MAX_CYCLES = 2000000;

    typedef struct packed {
        logic [XY_W-1:0]   x_scaled;
        logic [XY_W-1:0]   y_scaled;
        logic [Z_W-1:0]    z_scaled;
        logic [FLEN_W-1:0] point_index;
        logic              last_in_frame;
    } point_t;

    logic i_clk;
    logic i_rst_n;

    cas_in_if  in_ch();
    cas_out_if out_ch();
    cas_cfg_if cfg_ch();

    clifford_attractor_step_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // predictor state
    longint coef[4];
    longint scale_q;
    longint flen_q;
    longint px, py;
    longint fcount;
    point_t expected_pts[$];

    int  errors;
    bit  idle_on;
    longint cycles = 0;

    const longint ATAN_TAB[28] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 8
    };

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("clifford_attractor_step_top_test failed");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint sign_ext(longint v, int w);
        longint m;
        m = (longint'(1) << w) - 1;
        v = v & m;
        if (v[w-1]) v = v - (longint'(1) << w);
        return v;
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint r, x, y, t, dx, dy;
        bit neg_cos;
        r = ang <<< (30 - FRAC);
        x = GAIN_Q30;
        y = 0;
        neg_cos = 0;
        r = r % TWO_PI_Q30;
        if (r < 0) r += TWO_PI_Q30;
        if (r > PI_Q30) r -= TWO_PI_Q30;
        if (r > HALF_PI_Q30) begin
            r = PI_Q30 - r;
            neg_cos = 1;
        end else if (r < -HALF_PI_Q30) begin
            r = -PI_Q30 - r;
            neg_cos = 1;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (r >= 0) begin
                t = x - dx; y = y + dy; r -= ATAN_TAB[i];
            end else begin
                t = x + dx; y = y - dy; r += ATAN_TAB[i];
            end
            x = t;
        end
        if (neg_cos) x = -x;
        s = floor_shift(y + (longint'(1) << (29 - FRAC)), 30 - FRAC);
        c = floor_shift(x + (longint'(1) << (29 - FRAC)), 30 - FRAC);
    endtask

    function automatic longint clamp_pos(longint v);
        longint hi;
        hi = (longint'(1) << (POS_W - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    task automatic advance_point(input bit restart);
        longint a, b, c, d, s1, c1, s2, c2, s3, c3, s4, c4, sz, cz, nx, ny, fl;
        point_t p;
        a = sign_ext(coef[0], 20); b = sign_ext(coef[1], 20);
        c = sign_ext(coef[2], 20); d = sign_ext(coef[3], 20);
        fl = flen_q == 0 ? 1 : flen_q;
        if (restart) begin
            px = longint'(1) << FRAC;
            py = longint'(1) << FRAC;
            fcount = 0;
        end
        if (fcount >= fl) fcount = 0;
        sin_cos(floor_shift(a * py, FRAC), s1, c1);
        sin_cos(floor_shift(a * px, FRAC), s2, c2);
        sin_cos(floor_shift(b * px, FRAC), s3, c3);
        sin_cos(floor_shift(b * py, FRAC), s4, c4);
        sin_cos(px, sz, cz);
        nx = clamp_pos(s1 + floor_shift(c * c2, FRAC));
        ny = clamp_pos(s3 + floor_shift(d * c4, FRAC));
        px = nx;
        py = ny;
        p.x_scaled      = XY_W'(nx * scale_q);
        p.y_scaled      = XY_W'(ny * scale_q);
        p.z_scaled      = Z_W'(cz * scale_q);
        p.point_index   = FLEN_W'(fcount);
        p.last_in_frame = (fcount == fl - 1);
        expected_pts = {expected_pts, p};
        fcount = (fcount + 1 >= fl) ? 0 : fcount + 1;
    endtask

    task automatic random_gap();
        if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(negedge i_clk);
    endtask

    task automatic send_restart(input bit restart);
        // let the previous beat's release settle first
        if (in_ch.valid) @(negedge i_clk);
        random_gap();
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
        advance_point(restart);
        @(negedge i_clk);
        in_ch.valid   <= 1'b0;
        in_ch.restart <= $urandom_range(0, 1);
    endtask

    task automatic wait_drain();
        while (expected_pts.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        if (cfg_ch.valid) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_COEF_A:    coef[0] = value & 20'hFFFFF;
            REG_COEF_B:    coef[1] = value & 20'hFFFFF;
            REG_COEF_C:    coef[2] = value & 20'hFFFFF;
            REG_COEF_D:    coef[3] = value & 20'hFFFFF;
            REG_SCALE:     scale_q = value & 10'h3FF;
            REG_FRAME_LEN: flen_q  = value & 17'h1FFFF;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_all(input longint a, input longint b, input longint c,
                           input longint d, input longint s, input longint f);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, d);
        write_reg(REG_SCALE, s);
        write_reg(REG_FRAME_LEN, f);
    endtask

    // result checker with random back-pressure
    always @(posedge i_clk) begin
        point_t got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.x_scaled, out_ch.y_scaled, out_ch.z_scaled,
                   out_ch.point_index, out_ch.last_in_frame};
            if (expected_pts.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_pts.pop_front();
                if (got.x_scaled !== want.x_scaled) begin
                    $display("%0t: x_scaled expected %h actual %h", $time,
                             want.x_scaled, got.x_scaled);
                    errors++;
                end
                if (got.y_scaled !== want.y_scaled) begin
                    $display("%0t: y_scaled expected %h actual %h", $time,
                             want.y_scaled, got.y_scaled);
                    errors++;
                end
                if (got.z_scaled !== want.z_scaled) begin
                    $display("%0t: z_scaled expected %h actual %h", $time,
                             want.z_scaled, got.z_scaled);
                    errors++;
                end
                if (got.point_index !== want.point_index) begin
                    $display("%0t: point_index expected %0d actual %0d", $time,
                             want.point_index, got.point_index);
                    errors++;
                end
                if (got.last_in_frame !== want.last_in_frame) begin
                    $display("%0t: last_in_frame expected %b actual %b", $time,
                             want.last_in_frame, got.last_in_frame);
                    errors++;
                end
            end
        end
    end

    // sink drops ready at random while idle gaps are on
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic test_reset_defaults();
        coef[0] = RST_COEF_A; coef[1] = RST_COEF_B;
        coef[2] = RST_COEF_C; coef[3] = RST_COEF_D;
        scale_q = RST_SCALE; flen_q = RST_FLEN;
        px = longint'(1) << FRAC; py = px; fcount = 0;
        repeat (4) send_restart(1'b0);
        send_restart(1'b1);
        repeat (3) send_restart(1'b0);
        wait_drain();
    endtask

    task automatic test_extremes();
        // coefficients of -5.0, scale 1000, a one-point frame wraps every beat
        set_all(-327680, -327680, -327680, -327680, 1000, 1);
        repeat (4) send_restart(1'b0);
        wait_drain();
        set_all(327680, 327680, 327680, 327680, 1, 3);
        repeat (5) send_restart(1'b0);
        wait_drain();
        // zero frame length acts as one; zero, all-ones, max and min coefficients, max scale
        set_all(0, 20'hFFFFF, 20'h7FFFF, 20'h80000, 10'h3FF, 0);
        repeat (3) send_restart(1'b0);
        wait_drain();
        // lower frame length below a running counter
        set_all(91750, 104858, 65536, 111411, 100, 10);
        repeat (7) send_restart(1'b0);
        wait_drain();
        write_reg(REG_FRAME_LEN, 4);
        repeat (3) send_restart(1'b0);
        wait_drain();
        write_reg(REG_FRAME_LEN, 17'h1FFFF);
        send_restart(1'b1);
        wait_drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            set_all($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                    $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                    $urandom_range(0, 1023), ph == 0 ? 100000 : $urandom_range(1, 40));
            for (int n = 0; n < 200; n++) send_restart($urandom_range(0, 15) == 0);
            wait_drain();
        end
    endtask

    task automatic test_no_idle();
        idle_on = 0;
        set_all(91750, 104858, 65536, 111411, 1000, 7);
        for (int n = 0; n < 400; n++) send_restart($urandom_range(0, 31) == 0);
    endtask

    initial begin
        errors = 0;
        idle_on = 1;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.restart = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_COEF_A;
        cfg_ch.data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_extremes();
        test_random_phases();
        test_no_idle();
        wait_drain();
        if (errors == 0 && expected_pts.size() == 0) begin
            $display("clifford_attractor_step_top_test passed");
        end else begin
            $display("clifford_attractor_step_top_test failed");
        end
        $finish;
    end

endmodule

>>> clifford_attractor_step_top.f
rtl/core/cas_pkg.sv
rtl/core/cas_if.sv
rtl/core/cas_sincos.sv
rtl/core/clifford_attractor_step_top.sv
tb/clifford_attractor_step_top_test.sv
